// ----- hdl/erma_pkg.sv -----
// Package for the encoder rpm moving average block.
// Holds the field widths, the queue entry and state types, and the arithmetic constants.
// No dependencies.
package erma_pkg;

   localparam int TICK_W    = 16;
   localparam int MS_W      = 16;
   localparam int TPR_W     = 11;
   localparam int RPM_W     = 24;
   localparam int CONST_W   = 16;
   localparam int FRAC_BITS = 8;

   localparam logic [TPR_W-1:0]   TPR_RESET     = TPR_W'(20);
   localparam logic [CONST_W-1:0] RPM_PER_MIN_MS = CONST_W'(60000);
   localparam logic [TICK_W-1:0]  TICK_MAX      = {TICK_W{1'b1}};
   localparam logic [RPM_W-1:0]   SAMPLE_MAX    = {RPM_W{1'b1}};

   localparam int AVG_DEPTH = 8;
   localparam int PTR_W     = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
   localparam int SUM_W     = RPM_W + PTR_W;

   localparam int PROD_W = TICK_W + CONST_W;
   localparam int NUM_W  = PROD_W + FRAC_BITS;
   localparam int DEN_W  = TPR_W + MS_W;
   localparam int REM_W  = DEN_W + 1;
   localparam int CNT_W  = $clog2(NUM_W);

   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [TICK_W-1:0] ticks;
      logic [MS_W-1:0]   elapsed_ms;
      logic [TPR_W-1:0]  tpr;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MUL,
      BK_DIV,
      BK_DONE
   } back_state_type;

endpackage

// ----- hdl/erma_front.sv -----
// Front end: accepts input transactions, counts ticks and queues refresh commands.
// Also holds the ticks per revolution register. Depends on erma_pkg.
module erma_front
   import erma_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic                   req_kind,
   input  logic [MS_W-1:0]        req_elapsed_ms,
   input  logic                   csr_we,
   input  logic [TPR_W-1:0]       csr_wdata,
   input  queue_status_type       q_status,
   output logic                   q_push,
   output cmd_type                q_data
);

   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [TPR_W-1:0]  tpr_ff, tpr_in;
   logic              accept;

   assign req_full = q_status.full;
   assign accept   = req_push && !q_status.full;
   assign q_push   = accept && req_kind;

   assign q_data.ticks      = tick_ff;
   assign q_data.elapsed_ms = req_elapsed_ms;
   assign q_data.tpr        = tpr_ff;

   always_comb begin
      tick_in = tick_ff;
      if (accept) begin
         if (req_kind) begin
            tick_in = '0;
         end else if (tick_ff != TICK_MAX) begin
            tick_in = tick_ff + TICK_W'(1);
         end
      end
      tpr_in = csr_we ? csr_wdata : tpr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
         tpr_ff  <= TPR_RESET;
      end else begin
         tick_ff <= tick_in;
         tpr_ff  <= tpr_in;
      end
   end

endmodule

// ----- hdl/erma_queue.sv -----
// Short command queue between the front end and the back end.
// Depends on erma_pkg for the entry type and depth.
module erma_queue
   import erma_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_data,
   input  logic             pop,
   output cmd_type          pop_data,
   output queue_status_type status
);

   cmd_type             mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign status.full  = (cnt_ff == QCNT_W'(QDEPTH));
   assign status.empty = (cnt_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// ----- hdl/erma_back.sv -----
// Back end: multiplies, runs a restoring serial divide, updates the sample ring and
// running sum, and holds the result register. Depends on erma_pkg.
module erma_back
   import erma_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  queue_status_type  q_status,
   input  cmd_type           q_data,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [RPM_W-1:0]  rsp_sample_rpm,
   output logic [RPM_W-1:0]  rsp_average_rpm
);

   back_state_type     state_ff, state_in;
   cmd_type            cmd_ff, cmd_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [REM_W-1:0]   rem_ff, rem_in, rem_shift;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [RPM_W-1:0]   sample_ff, sample_in;
   logic [RPM_W-1:0]   ring_ff [AVG_DEPTH];
   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [RPM_W-1:0]   out_sample_ff, out_sample_in;
   logic [RPM_W-1:0]   out_avg_ff, out_avg_in;
   logic               out_valid_ff, out_valid_in;
   logic               out_pop, commit;
   logic [PROD_W-1:0]  prod;

   assign rsp_empty       = !out_valid_ff;
   assign rsp_sample_rpm  = out_sample_ff;
   assign rsp_average_rpm = out_avg_ff;
   assign out_pop         = rsp_pop && out_valid_ff;

   assign prod      = PROD_W'(cmd_ff.ticks) * PROD_W'(RPM_PER_MIN_MS);
   assign rem_shift = {rem_ff[REM_W-2:0], num_ff[NUM_W-1]};

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      sample_in     = sample_ff;
      ptr_in        = ptr_ff;
      sum_in        = sum_ff;
      out_sample_in = out_sample_ff;
      out_avg_in    = out_avg_ff;
      out_valid_in  = out_valid_ff && !out_pop;
      q_pop         = 1'b0;
      commit        = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               q_pop    = 1'b1;
               cmd_in   = q_data;
               state_in = BK_MUL;
            end
         end
         BK_MUL: begin
            num_in   = {prod, FRAC_BITS'(0)};
            den_in   = DEN_W'(cmd_ff.tpr) * DEN_W'(cmd_ff.elapsed_ms);
            rem_in   = '0;
            cnt_in   = '0;
            state_in = BK_DIV;
         end
         BK_DIV: begin
            if (rem_shift >= REM_W'(den_ff)) begin
               rem_in = rem_shift - REM_W'(den_ff);
               num_in = {num_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = rem_shift;
               num_in = {num_ff[NUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               if (den_ff == '0 || num_in[NUM_W-1:RPM_W] != '0) begin
                  sample_in = SAMPLE_MAX;
               end else begin
                  sample_in = num_in[RPM_W-1:0];
               end
               state_in = BK_DONE;
            end
         end
         BK_DONE: begin
            if (!out_valid_ff || out_pop) begin
               commit        = 1'b1;
               sum_in        = sum_ff - SUM_W'(ring_ff[ptr_ff]) + SUM_W'(sample_ff);
               ptr_in        = (ptr_ff == PTR_W'(AVG_DEPTH - 1)) ? '0 : ptr_ff + PTR_W'(1);
               out_sample_in = sample_ff;
               out_avg_in    = RPM_W'(sum_in / SUM_W'(AVG_DEPTH));
               out_valid_in  = 1'b1;
               state_in      = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
         ptr_ff       <= '0;
         sum_ff       <= '0;
         for (int i = 0; i < AVG_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         ptr_ff       <= ptr_in;
         sum_ff       <= sum_in;
         if (commit) begin
            ring_ff[ptr_ff] <= sample_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      sample_ff     <= sample_in;
      out_sample_ff <= out_sample_in;
      out_avg_ff    <= out_avg_in;
   end

endmodule

// ----- hdl/encoder_rpm_moving_average.sv -----
// Top level of the encoder rpm moving average block.
// Instantiates erma_front, erma_queue and erma_back; depends on erma_pkg.
//
// A tick transaction is taken and yields no result. A refresh transaction is queued
// and then worked on in the back end: a load, the two multiplications, the
// bit-at-a-time restoring divide of the 40-bit numerator, and an update of the ring,
// the running sum and the result register, which waits while a result is still held.
// Two refreshes may wait in the queue, and ticks keep counting while a refresh is
// worked on unless the queue is full. The result register holds one finished result
// until it is popped.
module encoder_rpm_moving_average
   import erma_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic              req_kind,
   input  logic [MS_W-1:0]   req_elapsed_ms,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [RPM_W-1:0]  rsp_sample_rpm,
   output logic [RPM_W-1:0]  rsp_average_rpm,
   input  logic              csr_we,
   input  logic [TPR_W-1:0]  csr_wdata
);

   queue_status_type q_status;
   logic             q_push, q_pop;
   cmd_type          q_wdata, q_rdata;

   erma_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_kind       (req_kind),
      .req_elapsed_ms (req_elapsed_ms),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .q_status       (q_status),
      .q_push         (q_push),
      .q_data         (q_wdata)
   );

   erma_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .status    (q_status)
   );

   erma_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_status        (q_status),
      .q_data          (q_rdata),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_sample_rpm  (rsp_sample_rpm),
      .rsp_average_rpm (rsp_average_rpm)
   );

endmodule

// ----- hdl/erma_checker.sv -----
// Port-level checker for the encoder rpm moving average block, with its bind.
// Depends on erma_pkg and the top level encoder_rpm_moving_average.
module erma_checker
   import erma_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_full,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input logic [RPM_W-1:0]  rsp_sample_rpm,
   input logic [RPM_W-1:0]  rsp_average_rpm
);

   // A waiting result that is not taken stays in place.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_sample_rpm)
                                    && $stable(rsp_average_rpm)))
      else $error("unpopped result changed");

   // Reset leaves no result to deliver.
   assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result present after reset");

   // Reset leaves room for new input transactions.
   assert property (@(posedge clock) reset |=> !req_full)
      else $error("input full after reset");

   // A refresh passes through the load, multiply, divide and update steps, so no result can show just after reset.
   assert property (@(posedge clock) $fell(reset) |-> ##2 rsp_empty)
      else $error("result appeared too soon after reset");

   // The result register empties only when a transaction takes it.
   assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_empty) && !$past(reset)) |-> $past(rsp_pop))
      else $error("result dropped without a pop");

endmodule

bind encoder_rpm_moving_average erma_checker u_erma_checker (.*);

// ----- tb/sv/tb.sv -----
// Testbench for encoder_rpm_moving_average: queue-style transactions in, queue-style results out.
// Predicts refresh results from its model of tick counter and sample ring, or fixed step values.
// Depends on erma_pkg and the encoder_rpm_moving_average RTL.
module tb;
   import erma_pkg::*;

   localparam logic KIND_TICK    = 1'b0;
   localparam logic KIND_REFRESH = 1'b1;

   localparam int          PHASES        = 8;
   localparam int          HOLD_PHASE    = 2;
   localparam int          QUIET_PHASE   = 4;
   localparam int          RANDOM_ITEMS  = 680;
   localparam int          SETTLE_CYCLES = 60;
   localparam int          HOLD_CYCLES   = 800;
   localparam int          IDLE_PERCENT  = 13;
   localparam int unsigned CYCLE_LIMIT   = 1_000_000;

   typedef enum logic [1:0] {
      ACT_TICK,
      ACT_REFRESH,
      ACT_SET_TPR
   } action_type;

   typedef struct {
      action_type       act;
      int unsigned      arg;
      int unsigned      reps;
      bit               fix_sample;
      bit               fix_average;
      logic [RPM_W-1:0] sample;
      logic [RPM_W-1:0] average;
   } step_type;

   typedef struct {
      logic [RPM_W-1:0] sample;
      logic [RPM_W-1:0] average;
   } rpm_result_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_push;
   logic              req_full;
   logic              req_kind;
   logic [MS_W-1:0]   req_elapsed_ms;
   logic              rsp_empty;
   logic              rsp_pop;
   logic [RPM_W-1:0]  rsp_sample_rpm;
   logic [RPM_W-1:0]  rsp_average_rpm;
   logic              csr_we;
   logic [TPR_W-1:0]  csr_wdata;

   step_type directed_steps [20] = '{
      '{ACT_REFRESH, 0,     1,     1, 1, 24'hFFFFFF, 24'h1FFFFF},
      '{ACT_REFRESH, 1000,  1,     1, 1, 24'h000000, 24'h1FFFFF},
      '{ACT_TICK,    0,     20,    0, 0, 24'h0,      24'h0},
      '{ACT_REFRESH, 1000,  1,     1, 0, 24'h003C00, 24'h0},
      '{ACT_TICK,    0,     40,    0, 0, 24'h0,      24'h0},
      '{ACT_REFRESH, 65535, 1,     0, 0, 24'h0,      24'h0},
      '{ACT_SET_TPR, 1,     1,     0, 0, 24'h0,      24'h0},
      '{ACT_TICK,    0,     30,    0, 0, 24'h0,      24'h0},
      '{ACT_REFRESH, 1,     1,     1, 0, 24'hFFFFFF, 24'h0},
      '{ACT_SET_TPR, 0,     1,     0, 0, 24'h0,      24'h0},
      '{ACT_TICK,    0,     3,     0, 0, 24'h0,      24'h0},
      '{ACT_REFRESH, 500,   1,     1, 0, 24'hFFFFFF, 24'h0},
      '{ACT_SET_TPR, 2047,  1,     0, 0, 24'h0,      24'h0},
      '{ACT_TICK,    0,     1,     0, 0, 24'h0,      24'h0},
      '{ACT_REFRESH, 65535, 1,     1, 0, 24'h000000, 24'h0},
      '{ACT_SET_TPR, 1024,  1,     0, 0, 24'h0,      24'h0},
      '{ACT_TICK,    0,     64,    0, 0, 24'h0,      24'h0},
      '{ACT_REFRESH, 3750,  1,     1, 0, 24'h000100, 24'h0},
      '{ACT_SET_TPR, 20,    1,     0, 0, 24'h0,      24'h0},
      '{ACT_REFRESH, 0,     1,     1, 0, 24'hFFFFFF, 24'h0}
   };

   logic [TICK_W-1:0] rpm_ticks;
   logic [RPM_W-1:0]  rpm_ring [AVG_DEPTH];
   int unsigned       rpm_slot;
   longint unsigned   rpm_sum;
   logic [TPR_W-1:0]  rpm_tpr;
   rpm_result_type    rpm_expected [$];

   int unsigned mismatches     = 0;
   int unsigned items_accepted = 0;
   int unsigned results_seen   = 0;
   int unsigned tpr_writes     = 0;
   int unsigned cycle_count    = 0;
   bit          no_idle        = 1'b0;
   bit          hold_request   = 1'b0;
   bit          hold_done      = 1'b0;

   encoder_rpm_moving_average DUT (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_kind        (req_kind),
      .req_elapsed_ms  (req_elapsed_ms),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_sample_rpm  (rsp_sample_rpm),
      .rsp_average_rpm (rsp_average_rpm),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic [RPM_W-1:0] rpm_from_ticks(input logic [TICK_W-1:0] ticks,
                                                       input logic [MS_W-1:0] ms,
                                                       input logic [TPR_W-1:0] tpr);
      longint unsigned num;
      longint unsigned den;
      longint unsigned quot;
      den = longint'(tpr) * longint'(ms);
      if (den == 0)
         return SAMPLE_MAX;
      num = (longint'(ticks) * longint'(RPM_PER_MIN_MS)) << FRAC_BITS;
      quot = num / den;
      if (quot > longint'(SAMPLE_MAX))
         return SAMPLE_MAX;
      return quot[RPM_W-1:0];
   endfunction

   function automatic logic [MS_W-1:0] pick_elapsed_ms();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 10)
         return '0;
      if (roll < 30)
         return MS_W'($urandom_range(64, 1));
      return MS_W'($urandom_range(16'hFFFF));
   endfunction

   // Offers one transaction, waits for acceptance and updates the prediction.
   task automatic send_item(input logic kind, input logic [MS_W-1:0] ms,
                            input bit fix_sample, input bit fix_average,
                            input logic [RPM_W-1:0] fixed_sample,
                            input logic [RPM_W-1:0] fixed_average);
      rpm_result_type next;
      logic [RPM_W-1:0] sample;
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_push = 1'b0;
         @(negedge clock);
      end
      req_push       = 1'b1;
      req_kind       = kind;
      req_elapsed_ms = ms;
      do
         @(posedge clock);
      while (req_full);
      items_accepted++;
      if (kind == KIND_REFRESH) begin
         sample = rpm_from_ticks(rpm_ticks, ms, rpm_tpr);
         rpm_ticks = '0;
         rpm_sum = rpm_sum - rpm_ring[rpm_slot] + sample;
         rpm_ring[rpm_slot] = sample;
         rpm_slot = (rpm_slot + 1) % AVG_DEPTH;
         next.sample  = fix_sample ? fixed_sample : sample;
         next.average = fix_average ? fixed_average : RPM_W'(rpm_sum / AVG_DEPTH);
         rpm_expected.push_back(next);
      end else if (rpm_ticks != TICK_MAX) begin
         rpm_ticks++;
      end
   endtask

   task automatic write_tpr(input logic [TPR_W-1:0] value);
      @(negedge clock);
      req_push = 1'b0;
      while (rpm_expected.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we  = 1'b0;
      rpm_tpr = value;
      tpr_writes++;
   endtask

   initial begin
      int unsigned target;
      int unsigned burst;
      logic [TPR_W-1:0] tpr;
      reset          = 1'b1;
      req_push       = 1'b0;
      req_kind       = KIND_TICK;
      req_elapsed_ms = '0;
      csr_we         = 1'b0;
      csr_wdata      = TPR_RESET;
      rpm_ticks      = '0;
      rpm_slot       = 0;
      rpm_sum        = 0;
      rpm_tpr        = TPR_RESET;
      foreach (rpm_ring[i])
         rpm_ring[i] = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_steps[i]) begin
         case (directed_steps[i].act)
            ACT_SET_TPR: begin
               write_tpr(TPR_W'(directed_steps[i].arg));
            end
            ACT_TICK: begin
               repeat (directed_steps[i].reps)
                  send_item(KIND_TICK, MS_W'($urandom_range(16'hFFFF)), 1'b0, 1'b0, '0, '0);
            end
            default: begin
               send_item(KIND_REFRESH, MS_W'(directed_steps[i].arg),
                         directed_steps[i].fix_sample, directed_steps[i].fix_average,
                         directed_steps[i].sample, directed_steps[i].average);
            end
         endcase
      end

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       tpr = TPR_RESET;
            1:       tpr = TPR_W'(1);
            2:       tpr = TPR_W'(1024);
            3:       tpr = '0;
            4:       tpr = '1;
            5:       tpr = TPR_W'($urandom_range(2047));
            default: tpr = TPR_W'($urandom_range(1024, 1));
         endcase
         write_tpr(tpr);
         hold_request = (p == HOLD_PHASE);
         no_idle      = (p == QUIET_PHASE);
         target       = items_accepted + RANDOM_ITEMS / PHASES;
         while (items_accepted < target) begin
            if (p == HOLD_PHASE)
               burst = $urandom_range(1);
            else if ($urandom_range(99) < 5)
               burst = $urandom_range(300, 30);
            else
               burst = $urandom_range(8);
            if (burst > target - items_accepted)
               burst = target - items_accepted;
            repeat (burst)
               send_item(KIND_TICK, MS_W'($urandom_range(16'hFFFF)), 1'b0, 1'b0, '0, '0);
            send_item(KIND_REFRESH, pick_elapsed_ms(), 1'b0, 1'b0, '0, '0);
         end
      end

      @(negedge clock);
      req_push = 1'b0;
      no_idle  = 1'b0;
      while (rpm_expected.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("Run accepted %0d input transactions and checked %0d results,",
               items_accepted, results_seen);
      $display("across %0d ticks-per-revolution settings including 0, 1, 1024 and 2047.",
               tpr_writes + 1);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // The result side pops at random and holds off once for a long stretch.
   initial begin
      int unsigned hold_left;
      rpm_result_type want;
      hold_left = 0;
      rsp_pop   = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_done && hold_left == 0)
            hold_left = HOLD_CYCLES;
         if (reset) begin
            rsp_pop = 1'b0;
         end else if (hold_left != 0) begin
            rsp_pop = 1'b0;
            hold_left--;
            if (hold_left == 0)
               hold_done = 1'b1;
         end else begin
            rsp_pop = no_idle || ($urandom_range(99) >= IDLE_PERCENT);
         end
         @(posedge clock);
         if (rsp_pop && !rsp_empty) begin
            results_seen++;
            if (rpm_expected.size() == 0) begin
               $error("Result transaction arrived with no expectation pending");
               mismatches++;
            end else begin
               want = rpm_expected.pop_front();
               if (rsp_sample_rpm !== want.sample) begin
                  $error("sample_rpm: expected %h, actual %h", want.sample, rsp_sample_rpm);
                  mismatches++;
               end
               if (rsp_average_rpm !== want.average) begin
                  $error("average_rpm: expected %h, actual %h", want.average, rsp_average_rpm);
                  mismatches++;
               end
            end
         end
      end
   end

endmodule
